>>> rtl/complex_to_real_convert_unit_assert.svh
// Assertion helpers for the converter; clk and rst_n must be in scope.
`ifndef COMPLEX_TO_REAL_CONVERT_UNIT_ASSERT_SVH
`define COMPLEX_TO_REAL_CONVERT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CTRC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CTRC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ctrc_pkg.sv
`timescale 1ns / 1ps
package ctrc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int GUARD_BITS       = 16;
  localparam int ANGLE_FRAC       = 24;
  localparam int ATAN_DEPTH       = 32;
  localparam int ZW               = ANGLE_FRAC + 3;

  typedef enum logic [1:0] {
    MODE_REAL     = 2'd0,
    MODE_IMAG     = 2'd1,
    MODE_MODULUS  = 2'd2,
    MODE_ARGUMENT = 2'd3
  } ctrc_mode_t;

  typedef struct packed {
    logic       valid;
    logic       frame_end;
    ctrc_mode_t mode;
    logic       zero;
  } ctrc_ctl_t;

  // atan(2^-i) in units of pi / 2^ANGLE_FRAC
  function automatic logic [ANGLE_FRAC-1:0] atan_at(input logic [4:0] idx);
    logic [ANGLE_FRAC-1:0] v;
    case (idx)
      5'd0:  v = 24'd4194304;
      5'd1:  v = 24'd2476042;
      5'd2:  v = 24'd1308273;
      5'd3:  v = 24'd664100;
      5'd4:  v = 24'd333339;
      5'd5:  v = 24'd166832;
      5'd6:  v = 24'd83436;
      5'd7:  v = 24'd41721;
      5'd8:  v = 24'd20861;
      5'd9:  v = 24'd10430;
      5'd10: v = 24'd5215;
      5'd11: v = 24'd2608;
      5'd12: v = 24'd1304;
      5'd13: v = 24'd652;
      5'd14: v = 24'd326;
      5'd15: v = 24'd163;
      5'd16: v = 24'd81;
      5'd17: v = 24'd41;
      5'd18: v = 24'd20;
      5'd19: v = 24'd10;
      5'd20: v = 24'd5;
      5'd21: v = 24'd3;
      5'd22: v = 24'd1;
      5'd23: v = 24'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ctrc_front.sv
`timescale 1ns / 1ps
module ctrc_front import ctrc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] in_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_imag,
  input  logic                           in_frame_end,
  input  ctrc_mode_t                     mode,
  output ctrc_ctl_t                      ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0] re_o,
  output logic signed [SAMPLE_WIDTH-1:0] im_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic [2*SAMPLE_WIDTH:0]        n_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int XW  = W + GUARD_BITS + 3;
  localparam int SQW = 2 * W + 1;

  ctrc_ctl_t               ctl_r, ctl_nxt;
  logic signed [W-1:0]     re_r, im_r;
  logic signed [XW-1:0]    x_r, x_nxt, y_r, y_nxt, re_x, im_x;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic [SQW-1:0]          n_r, n_nxt;
  logic signed [2*W-1:0]   sq_re, sq_im;

  always_comb begin
    ctl_nxt.valid     = in_valid;
    ctl_nxt.frame_end = in_frame_end;
    ctl_nxt.mode      = mode;
    ctl_nxt.zero      = (in_real == '0) && (in_imag == '0);

    sq_re = (2*W)'(in_real) * (2*W)'(in_real);
    sq_im = (2*W)'(in_imag) * (2*W)'(in_imag);
    n_nxt = SQW'($unsigned(sq_re)) + SQW'($unsigned(sq_im));

    re_x  = XW'(in_real) <<< GUARD_BITS;
    im_x  = XW'(in_imag) <<< GUARD_BITS;
    x_nxt = re_x;
    y_nxt = im_x;
    z_nxt = '0;
    // fold a left-half-plane vector into the right half by a quarter turn
    if (in_real[W-1]) begin
      if (!in_imag[W-1]) begin
        x_nxt = im_x;
        y_nxt = -re_x;
        z_nxt = ZW'(1) <<< (ANGLE_FRAC - 1);
      end else begin
        x_nxt = -im_x;
        y_nxt = re_x;
        z_nxt = -(ZW'(1) <<< (ANGLE_FRAC - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= in_real;
    im_r <= in_imag;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    n_r  <= n_nxt;
  end

  assign ctl_o = ctl_r;
  assign re_o  = re_r;
  assign im_o  = im_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign n_o   = n_r;

endmodule

>>> rtl/ctrc_stage.sv
`timescale 1ns / 1ps
module ctrc_stage import ctrc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int K            = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctrc_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_i,
  input  logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_i,
  input  logic signed [ZW-1:0]           z_i,
  input  logic [2*SAMPLE_WIDTH:0]        n_i,
  input  logic [2*SAMPLE_WIDTH:0]        r_i,
  output ctrc_ctl_t                      ctl_o,
  output logic signed [SAMPLE_WIDTH-1:0] re_o,
  output logic signed [SAMPLE_WIDTH-1:0] im_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] x_o,
  output logic signed [SAMPLE_WIDTH+GUARD_BITS+2:0] y_o,
  output logic signed [ZW-1:0]           z_o,
  output logic [2*SAMPLE_WIDTH:0]        n_o,
  output logic [2*SAMPLE_WIDTH:0]        r_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int XW  = W + GUARD_BITS + 3;
  localparam int SQW = 2 * W + 1;

  ctrc_ctl_t             ctl_r;
  logic signed [W-1:0]   re_r, im_r;
  logic signed [XW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [SQW-1:0]        n_r, n_nxt, r_r, r_nxt;

  // one digit of the square root per stage
  if (K < W) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (W - 1 - K));
    logic [SQW-1:0] trial;
    always_comb begin
      trial = r_i + BIT;
      if (n_i >= trial) begin
        n_nxt = n_i - trial;
        r_nxt = (r_i >> 1) + BIT;
      end else begin
        n_nxt = n_i;
        r_nxt = r_i >> 1;
      end
    end
  end else begin : g_sqrt_hold
    assign n_nxt = n_i;
    assign r_nxt = r_i;
  end

  // one micro-rotation per stage, driving y toward zero
  if (K < CORDIC_STEPS && K < ATAN_DEPTH) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_at(5'(K)));
    logic signed [XW-1:0] xs, ys;
    always_comb begin
      xs = x_i >>> K;
      ys = y_i >>> K;
      if (y_i > 0) begin
        x_nxt = x_i + ys;
        y_nxt = y_i - xs;
        z_nxt = z_i + ANG;
      end else begin
        x_nxt = x_i - ys;
        y_nxt = y_i + xs;
        z_nxt = z_i - ANG;
      end
    end
  end else begin : g_rot_hold
    assign x_nxt = x_i;
    assign y_nxt = y_i;
    assign z_nxt = z_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_i;
    im_r <= im_i;
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    z_r  <= z_nxt;
    n_r  <= n_nxt;
    r_r  <= r_nxt;
  end

  assign ctl_o = ctl_r;
  assign re_o  = re_r;
  assign im_o  = im_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign n_o   = n_r;
  assign r_o   = r_r;

endmodule

>>> rtl/ctrc_back.sv
`timescale 1ns / 1ps
module ctrc_back import ctrc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctrc_ctl_t                      ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [SAMPLE_WIDTH-1:0] im_i,
  input  logic signed [ZW-1:0]           z_i,
  input  logic [2*SAMPLE_WIDTH:0]        n_i,
  input  logic [2*SAMPLE_WIDTH:0]        r_i,
  output ctrc_ctl_t                      ctl_o,
  output logic signed [SAMPLE_WIDTH:0]   value_o
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int AW  = ZW + W + 1;
  localparam int RSH = ANGLE_FRAC - (W - 1);
  localparam logic signed [AW-1:0] LIM = AW'(1) <<< (W - 1);

  ctrc_ctl_t            ctl_r;
  logic signed [W:0]    value_r, value_nxt;
  logic signed [AW-1:0] z_ext, ang_scaled, ang;
  logic [W:0]           root;

  assign z_ext = AW'(z_i);

  // round half up to output angle units
  if (RSH > 0) begin : g_shr
    assign ang_scaled = (z_ext + (AW'(1) <<< (RSH - 1))) >>> RSH;
  end else if (RSH == 0) begin : g_same
    assign ang_scaled = z_ext;
  end else begin : g_shl
    assign ang_scaled = z_ext <<< (-RSH);
  end

  always_comb begin
    ang = ang_scaled;
    if (ang > LIM) begin
      ang = LIM;
    end
    if (ang < -LIM) begin
      ang = -LIM;
    end
    if (ctl_i.zero) begin
      ang = '0;
    end

    // round the root up when the remainder exceeds it
    root = r_i[W:0];
    if (n_i > r_i) begin
      root = root + 1'b1;
    end

    case (ctl_i.mode)
      MODE_REAL:    value_nxt = (W+1)'(re_i);
      MODE_IMAG:    value_nxt = (W+1)'(im_i);
      MODE_MODULUS: value_nxt = $signed(root);
      default:      value_nxt = ang[W:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign ctl_o   = ctl_r;
  assign value_o = value_r;

endmodule

>>> rtl/complex_to_real_convert_unit.sv
// Structure: one input stage, one stage per root digit / CORDIC step, one output stage.
// Throughput: one item per clock; busy is low whenever rst_n is high.
// Reset (synchronous, rst_n low): empties the pipeline and sets mode to the real part.
`timescale 1ns / 1ps
`include "complex_to_real_convert_unit_assert.svh"
module complex_to_real_convert_unit import ctrc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] in_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_imag,
  input  logic                           in_frame_end,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_data,
  output logic                           out_strobe,
  output logic signed [SAMPLE_WIDTH:0]   out_value,
  output logic                           out_frame_end
);

  localparam int W      = SAMPLE_WIDTH;
  localparam int XW     = W + GUARD_BITS + 3;
  localparam int SQW    = 2 * W + 1;
  localparam int CSTEPS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
  localparam int NS     = (W > CSTEPS) ? W : CSTEPS;
  localparam int LAT    = NS + 2;
  localparam logic signed [W:0] ANG_LIM = (W+1)'(1) <<< (W - 1);

  ctrc_mode_t mode_r, mode_nxt;
  logic       in_valid;
  logic       arg_strobe, arg_in_range;

  ctrc_ctl_t             ctl_s [0:NS];
  logic signed [W-1:0]   re_s  [0:NS];
  logic signed [W-1:0]   im_s  [0:NS];
  logic signed [XW-1:0]  x_s   [0:NS];
  logic signed [XW-1:0]  y_s   [0:NS];
  logic signed [ZW-1:0]  z_s   [0:NS];
  logic [SQW-1:0]        n_s   [0:NS];
  logic [SQW-1:0]        r_s   [0:NS];
  ctrc_ctl_t             ctl_out;

  assign busy     = !rst_n;
  assign in_valid = start && !busy;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_we) begin
      mode_nxt = ctrc_mode_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_REAL;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  ctrc_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_real     (in_real),
    .in_imag     (in_imag),
    .in_frame_end(in_frame_end),
    .mode        (mode_r),
    .ctl_o       (ctl_s[0]),
    .re_o        (re_s[0]),
    .im_o        (im_s[0]),
    .x_o         (x_s[0]),
    .y_o         (y_s[0]),
    .z_o         (z_s[0]),
    .n_o         (n_s[0])
  );

  assign r_s[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    ctrc_stage #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .CORDIC_STEPS(CORDIC_STEPS),
      .K           (k)
    ) u_stage (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl_i(ctl_s[k]),
      .re_i (re_s[k]),
      .im_i (im_s[k]),
      .x_i  (x_s[k]),
      .y_i  (y_s[k]),
      .z_i  (z_s[k]),
      .n_i  (n_s[k]),
      .r_i  (r_s[k]),
      .ctl_o(ctl_s[k+1]),
      .re_o (re_s[k+1]),
      .im_o (im_s[k+1]),
      .x_o  (x_s[k+1]),
      .y_o  (y_s[k+1]),
      .z_o  (z_s[k+1]),
      .n_o  (n_s[k+1]),
      .r_o  (r_s[k+1])
    );
  end

  ctrc_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_s[NS]),
    .re_i   (re_s[NS]),
    .im_i   (im_s[NS]),
    .z_i    (z_s[NS]),
    .n_i    (n_s[NS]),
    .r_i    (r_s[NS]),
    .ctl_o  (ctl_out),
    .value_o(out_value)
  );

  assign out_strobe    = ctl_out.valid;
  assign out_frame_end = ctl_out.frame_end;

  assign arg_strobe   = out_strobe && (ctl_out.mode == MODE_ARGUMENT);
  assign arg_in_range = (out_value <= ANG_LIM) && (out_value >= -ANG_LIM);

  `CTRC_ASSERT_IMP(a_strobe_follows_accept, out_strobe, $past(in_valid, LAT), "result without item")
  `CTRC_ASSERT_IMP(a_angle_in_range, arg_strobe, arg_in_range, "angle out of range")
  `CTRC_ASSERT_NEXT(a_mode_written, cfg_we, mode_r == ctrc_mode_t'($past(cfg_data)), "mode not taken")

endmodule

>>> verif/complex_to_real_convert_unit_test.sv
`timescale 1ns / 1ps
module complex_to_real_convert_unit_test;
  import ctrc_pkg::*;

  localparam int LATENCY      = 18;
  localparam int SAMPLE_COUNT = 1300;
  localparam int QUIET_TAIL   = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int PROBE_ROWS   = 22;

  typedef struct {
    logic signed [16:0] value;
    logic               frame_end;
  } conv_result_t;

  typedef struct {
    ctrc_mode_t mode;
    int         re;
    int         im;
    bit         fe;
    bit         typed;
    int         value;
  } probe_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic signed [15:0] in_real       = '0;
  logic signed [15:0] in_imag       = '0;
  logic               in_frame_end  = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [1:0]         cfg_data      = '0;
  logic               out_strobe;
  logic signed [16:0] out_value;
  logic               out_frame_end;

  conv_result_t pending_results [$];
  ctrc_mode_t   mode_now     = MODE_REAL;
  bit           failed       = 1'b0;
  int           idle_cycles  = 0;
  int           samples_sent = 0;
  probe_row_t   probes [PROBE_ROWS];
  int           corner_values [5] = '{-32768, -1, 0, 1, 32767};

  // atan(2^-i) in units of pi / 2^24
  longint arctan_units [16] = '{
    4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
    20861, 10430, 5215, 2608, 1304, 652, 326, 163
  };

  complex_to_real_convert_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_real      (in_real),
    .in_imag      (in_imag),
    .in_frame_end (in_frame_end),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_strobe   (out_strobe),
    .out_value    (out_value),
    .out_frame_end(out_frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Square root of s, rounded half up.
  function automatic longint rounded_root(longint s);
    longint n, r, digit;
    n = s;
    r = 0;
    digit = longint'(1) <<< 40;
    while (digit > n) digit = digit >>> 2;
    while (digit != 0) begin
      if (n >= r + digit) begin
        n = n - (r + digit);
        r = (r >>> 1) + digit;
      end else begin
        r = r >>> 1;
      end
      digit = digit >>> 2;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic longint cordic_angle(logic signed [15:0] re, logic signed [15:0] im);
    longint x, y, z, t, xs, ys, angle;
    if (re == 0 && im == 0) return 0;
    x = longint'(re) <<< 16;
    y = longint'(im) <<< 16;
    z = 0;
    // Fold the left half plane by a quarter turn first.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        z = longint'(1) <<< 23;
      end else begin
        t = x; x = -y; y = t;
        z = -(longint'(1) <<< 23);
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + arctan_units[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_units[i];
      end
    end
    angle = (z + 256) >>> 9;
    if (angle > 32768) angle = 32768;
    if (angle < -32768) angle = -32768;
    return angle;
  endfunction

  function automatic logic signed [16:0] predict_value(ctrc_mode_t m, logic signed [15:0] re,
                                                       logic signed [15:0] im);
    longint v;
    case (m)
      MODE_REAL:    v = re;
      MODE_IMAG:    v = im;
      MODE_MODULUS: v = rounded_root(longint'(re) * longint'(re) + longint'(im) * longint'(im));
      default:      v = cordic_angle(re, im);
    endcase
    return v[16:0];
  endfunction

  task automatic pause_input(int n);
    @(negedge clk) start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop start, wait for every result, then let the pipeline settle.
  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_mode(ctrc_mode_t m);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(negedge clk) cfg_we <= 1'b0;
    mode_now = m;
  endtask

  task automatic send_sample(int re, int im, bit fe, bit typed, int typed_value);
    conv_result_t want;
    @(negedge clk);
    start        <= 1'b1;
    in_real      <= 16'(re);
    in_imag      <= 16'(im);
    in_frame_end <= fe;
    do @(posedge clk); while (busy);
    want.value     = typed ? 17'(typed_value) : predict_value(mode_now, 16'(re), 16'(im));
    want.frame_end = fe;
    pending_results.push_back(want);
    samples_sent++;
  endtask

  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected item: expected none, actual value=%0d frame_end=%0b",
                 $time, out_value, out_frame_end);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) begin
          failed = 1'b1;
          $display("%0t: value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_value);
        end
        if (out_frame_end !== want.frame_end) begin
          failed = 1'b1;
          $display("%0t: frame_end mismatch: expected %0b, actual %0b",
                   $time, want.frame_end, out_frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[complex_to_real_convert_unit] ERROR");
      $finish;
    end
  end

  initial begin
    int         re, im, phase_len, idle_pct;
    bit         fe;
    ctrc_mode_t m;
    probes = '{
      '{MODE_REAL,     0,      0,      1'b0, 1'b1, 0},
      '{MODE_REAL,     -32768, 5,      1'b1, 1'b1, -32768},
      '{MODE_REAL,     32767,  -1,     1'b0, 1'b1, 32767},
      '{MODE_IMAG,     123,    -32768, 1'b0, 1'b1, -32768},
      '{MODE_IMAG,     -1,     32767,  1'b1, 1'b1, 32767},
      '{MODE_IMAG,     21845,  10922,  1'b0, 1'b0, 0},
      '{MODE_MODULUS,  0,      0,      1'b0, 1'b1, 0},
      '{MODE_MODULUS,  -32768, -32768, 1'b1, 1'b1, 46341},
      '{MODE_MODULUS,  -32768, 0,      1'b0, 1'b1, 32768},
      '{MODE_MODULUS,  32767,  32767,  1'b0, 1'b0, 0},
      '{MODE_MODULUS,  3,      4,      1'b1, 1'b1, 5},
      '{MODE_MODULUS,  1,      1,      1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, 0,      0,      1'b0, 1'b1, 0},
      '{MODE_ARGUMENT, -32768, 0,      1'b1, 1'b0, 0},
      '{MODE_ARGUMENT, -1,     0,      1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, 32767,  0,      1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, 0,      32767,  1'b1, 1'b0, 0},
      '{MODE_ARGUMENT, 0,      -32768, 1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, -32768, -32768, 1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, -32768, 1,      1'b1, 1'b0, 0},
      '{MODE_ARGUMENT, -32768, -1,     1'b0, 1'b0, 0},
      '{MODE_ARGUMENT, 1,      -1,     1'b1, 1'b0, 0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // First rows run in the reset mode, so no write precedes them.
    foreach (probes[k]) begin
      if (probes[k].mode != mode_now) write_mode(probes[k].mode);
      send_sample(probes[k].re, probes[k].im, probes[k].fe, probes[k].typed, probes[k].value);
    end

    while (samples_sent < SAMPLE_COUNT) begin
      m = ctrc_mode_t'($urandom_range(0, 3));
      write_mode(m);
      phase_len = $urandom_range(40, 160);
      idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
      for (int k = 0; k < phase_len && samples_sent < SAMPLE_COUNT; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            re = corner_values[$urandom_range(0, 4)];
            im = corner_values[$urandom_range(0, 4)];
          end
          1: begin
            // Land on an axis, the negative real axis among them.
            re = int'($urandom_range(0, 65535)) - 32768;
            im = 0;
            if ($urandom_range(0, 1) == 1) begin
              im = re;
              re = 0;
            end
          end
          2: begin
            re = int'($urandom_range(0, 16)) - 8;
            im = int'($urandom_range(0, 16)) - 8;
          end
          default: begin
            re = int'($urandom_range(0, 65535)) - 32768;
            im = int'($urandom_range(0, 65535)) - 32768;
          end
        endcase
        fe = ($urandom_range(0, 7) == 0);
        if (samples_sent < SAMPLE_COUNT - QUIET_TAIL && idle_pct != 0 &&
            $urandom_range(0, 99) < idle_pct)
          pause_input($urandom_range(1, 10));
        send_sample(re, im, fe, 1'b0, 0);
      end
    end

    drain_results();
    if (!failed) begin
      $display("[complex_to_real_convert_unit] OK");
    end else begin
      $display("[complex_to_real_convert_unit] ERROR");
    end
    $finish;
  end

endmodule
